FILE: rtl/tvc_pkg.sv
// tvc_pkg: types and constants shared by the velocity constraint cost block.
// No dependencies; used by tvc_front, tvc_back and the top level.
`default_nettype none

package tvc_pkg;

    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [2:0] CFG_ENABLE      = 3'd0;
    localparam logic [2:0] CFG_POW_EXP     = 3'd1;
    localparam logic [2:0] CFG_WEIGHT      = 3'd2;
    localparam logic [2:0] CFG_MAX_SPEED   = 3'd3;
    localparam logic [2:0] CFG_MIN_SPEED   = 3'd4;
    localparam logic [2:0] CFG_STEP_TIME   = 3'd5;
    localparam logic [2:0] CFG_ACKERMANN   = 3'd6;
    localparam logic [2:0] CFG_MIN_RADIUS  = 3'd7;

    localparam logic [31:0] OUT_MAX = 32'hFFFF_FFFF;
    localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    // classified step as held in the queue
    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] awz;
        logic        vx_pos;
        logic        wz_zero;
        logic        last;
    } step_t;

    typedef struct packed {
        logic        enable;
        logic [2:0]  pow_exp;
        logic [15:0] weight_q8;
        logic [15:0] max_speed;
        logic [15:0] min_speed;
        logic [15:0] step_time;
        logic        ackermann_mode;
        logic [15:0] min_turn_radius;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/tvc_front.sv
// tvc_front: accepts steps, takes magnitudes and flags, and queues them.
// Depends on tvc_pkg.
`default_nettype none

module tvc_front
    import tvc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] vel_x,
    input  wire logic [15:0] vel_y,
    input  wire logic [15:0] yaw_rate,
    input  wire logic        last_step,
    output logic             head_valid,
    output step_t            head,
    input  wire logic        pop
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    step_t           mem [DEPTH];
    logic [IW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            push;
    step_t           cls;

    function automatic logic [15:0] mag16(input logic [15:0] v);
        return v[15] ? (~v + 16'd1) : v;
    endfunction

    always_comb
    begin
        cls.ax      = mag16(vel_x);
        cls.ay      = mag16(vel_y);
        cls.awz     = mag16(yaw_rate);
        cls.vx_pos  = !vel_x[15] && (vel_x != 16'd0);
        cls.wz_zero = (yaw_rate == 16'd0);
        cls.last    = last_step;
    end

    assign in_stall   = (cnt_reg == FULL_CNT);
    assign push       = in_valid && !in_stall;
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + IW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + IW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tvc_back.sv
// tvc_back: per-step penalty (iterative sqrt and divide), accumulation and
// final weighted power. Depends on tvc_pkg.
`default_nettype none

module tvc_back
    import tvc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  head_valid,
    input  wire step_t head,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [31:0] trajectory_cost
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQX   = 4'd1;
    localparam logic [3:0] ST_SQY   = 4'd2;
    localparam logic [3:0] ST_ITER  = 4'd3;
    localparam logic [3:0] ST_PEN   = 4'd4;
    localparam logic [3:0] ST_SCALE = 4'd5;
    localparam logic [3:0] ST_ACC   = 4'd6;
    localparam logic [3:0] ST_WLO   = 4'd7;
    localparam logic [3:0] ST_WHI   = 4'd8;
    localparam logic [3:0] ST_WSUM  = 4'd9;
    localparam logic [3:0] ST_POW   = 4'd10;
    localparam logic [3:0] ST_EMIT  = 4'd11;

    localparam logic [4:0] ITER_LAST = 5'd27;
    localparam logic [4:0] SQRT_STEPS = 5'd16;

    logic [3:0]  state_reg;
    step_t       cur_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] sq_v_reg;
    logic [31:0] sq_res_reg;
    logic [27:0] dv_reg;
    logic [16:0] rem_reg;
    logic [27:0] q_reg;
    logic [21:0] pen_reg;
    logic [25:0] add_reg;
    logic [39:0] sum_reg;
    logic [35:0] p_lo_reg;
    logic [35:0] p_hi_reg;
    logic [31:0] x_reg;
    logic [31:0] y_reg;
    logic [2:0]  pcnt_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    // one divide step per ST_ITER cycle, plus one sqrt step while cnt_reg < SQRT_STEPS
    logic [31:0] sq_bit;
    logic [31:0] sq_t;
    logic [16:0] div_r;

    // penalty terms
    logic signed [17:0] spd;
    logic signed [18:0] exc;
    logic signed [18:0] sho;
    logic signed [29:0] rad;
    logic [21:0]        pen;

    logic [40:0] acc_sum;
    logic [55:0] wfull;
    logic [63:0] pow_prod;
    logic [47:0] pow_shift;
    logic        slot_free;

    always_comb
    begin
        sq_bit = 32'h4000_0000 >> {cnt_reg, 1'b0};
        sq_t   = sq_res_reg + sq_bit;
        div_r  = {rem_reg[15:0], dv_reg[27]};
    end

    always_comb
    begin
        spd = cur_reg.vx_pos ? $signed({1'b0, sq_res_reg[16:0]})
                             : -$signed({1'b0, sq_res_reg[16:0]});
        exc = 19'(spd) - 19'($signed(cfg.max_speed));
        sho = 19'($signed(cfg.min_speed)) - 19'(spd);
        rad = $signed({10'd0, cfg.min_turn_radius, 4'd0}) - $signed({2'd0, q_reg});
        pen = '0;
        if (exc > 0)
        begin
            pen = pen + 22'(exc);
        end
        if (sho > 0)
        begin
            pen = pen + 22'(sho);
        end
        if (cfg.ackermann_mode && !cur_reg.wz_zero && rad > 0)
        begin
            pen = pen + 22'(rad);
        end
    end

    always_comb
    begin
        acc_sum   = {1'b0, sum_reg} + {15'd0, add_reg};
        wfull     = {p_hi_reg, 20'd0} + {20'd0, p_lo_reg};
        pow_prod  = y_reg * x_reg;
        pow_shift = pow_prod[63:16];
        slot_free = !out_valid_reg || !out_stall;
        pop       = (state_reg == ST_IDLE) && head_valid;
    end

    assign out_valid       = out_valid_reg;
    assign trajectory_cost = out_data_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                cur_reg <= head;
                y_reg   <= '0;
            end
            ST_SQX:
            begin
                sq_v_reg   <= {16'd0, cur_reg.ax} * {16'd0, cur_reg.ax};
                sq_res_reg <= '0;
                dv_reg     <= {cur_reg.ax, 12'd0};
                rem_reg    <= '0;
                q_reg      <= '0;
            end
            ST_SQY:
            begin
                sq_v_reg <= sq_v_reg + {16'd0, cur_reg.ay} * {16'd0, cur_reg.ay};
            end
            ST_ITER:
            begin
                if (cnt_reg < SQRT_STEPS)
                begin
                    if (sq_v_reg >= sq_t)
                    begin
                        sq_v_reg   <= sq_v_reg - sq_t;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit;
                    end
                    else
                    begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                end
                dv_reg <= {dv_reg[26:0], 1'b0};
                if (!cur_reg.wz_zero && div_r >= {1'b0, cur_reg.awz})
                begin
                    rem_reg <= div_r - {1'b0, cur_reg.awz};
                    q_reg   <= {q_reg[26:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_r;
                    q_reg   <= {q_reg[26:0], 1'b0};
                end
            end
            ST_PEN:
            begin
                pen_reg <= pen;
            end
            ST_SCALE:
            begin
                add_reg <= 26'((38'(pen_reg) * 38'(cfg.step_time)) >> 12);
            end
            ST_WLO:
            begin
                p_lo_reg <= {16'd0, sum_reg[19:0]} * {20'd0, cfg.weight_q8};
            end
            ST_WHI:
            begin
                p_hi_reg <= {16'd0, sum_reg[39:20]} * {20'd0, cfg.weight_q8};
            end
            ST_WSUM:
            begin
                x_reg <= (wfull[55:40] != '0) ? OUT_MAX : wfull[39:8];
                y_reg <= ONE_Q16;
            end
            ST_POW:
            begin
                if (pcnt_reg != cfg.pow_exp)
                begin
                    y_reg <= (pow_shift[47:32] != '0) ? OUT_MAX : pow_shift[31:0];
                end
            end
            ST_ACC, ST_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_EMIT && slot_free)
        begin
            out_data_reg <= y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pcnt_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_EMIT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        if (cfg.enable)
                        begin
                            state_reg <= ST_SQX;
                        end
                        else if (head.last)
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_SQX:
                begin
                    state_reg <= ST_SQY;
                end
                ST_SQY:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_ITER;
                end
                ST_ITER:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == ITER_LAST)
                    begin
                        state_reg <= ST_PEN;
                    end
                end
                ST_PEN:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    sum_reg   <= acc_sum[40] ? SUM_MAX : acc_sum[39:0];
                    state_reg <= cur_reg.last ? ST_WLO : ST_IDLE;
                end
                ST_WLO:
                begin
                    state_reg <= ST_WHI;
                end
                ST_WHI:
                begin
                    state_reg <= ST_WSUM;
                end
                ST_WSUM:
                begin
                    pcnt_reg  <= '0;
                    state_reg <= ST_POW;
                end
                ST_POW:
                begin
                    if (pcnt_reg == cfg.pow_exp)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        pcnt_reg <= pcnt_reg + 3'd1;
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        sum_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/trajectory_velocity_constraint_cost.sv
// Velocity constraint cost: one request per trajectory step, one result per trajectory.
// Each step runs through the back end, with one shared sqrt/divide iteration;
// the last step adds weighting and the power loop.
// With enable low a step is popped without processing and the last one emits 0.
// The front queue holds DEPTH steps, QUEUE_DEPTH by default. rst_n clears the sum,
// queue and output, and loads the register defaults.
`default_nettype none

module trajectory_velocity_constraint_cost
    import tvc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] vel_x,
    input  wire logic [15:0] vel_y,
    input  wire logic [15:0] yaw_rate,
    input  wire logic        last_step,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      trajectory_cost
);

    cfg_t  cfg_reg;
    logic  head_valid;
    step_t head;
    logic  pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable          <= 1'b1;
            cfg_reg.pow_exp         <= 3'd1;
            cfg_reg.weight_q8       <= 16'd1024;
            cfg_reg.max_speed       <= 16'h1000;
            cfg_reg.min_speed       <= 16'hF000;
            cfg_reg.step_time       <= 16'd3277;
            cfg_reg.ackermann_mode  <= 1'b0;
            cfg_reg.min_turn_radius <= 16'd256;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ENABLE:      cfg_reg.enable          <= cfg_data[0];
                CFG_POW_EXP:     cfg_reg.pow_exp         <= cfg_data[2:0];
                CFG_WEIGHT:      cfg_reg.weight_q8       <= cfg_data;
                CFG_MAX_SPEED:   cfg_reg.max_speed       <= cfg_data;
                CFG_MIN_SPEED:   cfg_reg.min_speed       <= cfg_data;
                CFG_STEP_TIME:   cfg_reg.step_time       <= cfg_data;
                CFG_ACKERMANN:   cfg_reg.ackermann_mode  <= cfg_data[0];
                CFG_MIN_RADIUS:  cfg_reg.min_turn_radius <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tvc_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .yaw_rate   (yaw_rate),
        .last_step  (last_step),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    tvc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .trajectory_cost (trajectory_cost)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for trajectory_velocity_constraint_cost: directed cases and random
// trajectories, a bit-exact cost predictor and an in-order result scoreboard. Needs tvc_pkg.
`timescale 1ns / 1ps

class cost_board;
    logic        enable;
    logic [2:0]  pow_exp;
    logic [15:0] weight_q8;
    logic signed [15:0] max_speed;
    logic signed [15:0] min_speed;
    logic [15:0] step_time;
    logic        ackermann_mode;
    logic [15:0] min_turn_radius;
    logic [39:0] penalty_sum;
    logic [31:0] pending_costs[$];
    int          errors;

    function new();
        enable = 1;
        pow_exp = 1;
        weight_q8 = 1024;
        max_speed = 16'sd4096;
        min_speed = -16'sd4096;
        step_time = 3277;
        ackermann_mode = 0;
        min_turn_radius = 256;
        penalty_sum = 0;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            tvc_pkg::CFG_ENABLE:      enable = val[0];
            tvc_pkg::CFG_POW_EXP:     pow_exp = val[2:0];
            tvc_pkg::CFG_WEIGHT:      weight_q8 = val;
            tvc_pkg::CFG_MAX_SPEED:   max_speed = val;
            tvc_pkg::CFG_MIN_SPEED:   min_speed = val;
            tvc_pkg::CFG_STEP_TIME:   step_time = val;
            tvc_pkg::CFG_ACKERMANN:   ackermann_mode = val[0];
            default:                  min_turn_radius = val;
        endcase
    endfunction

    function longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function void note_step(logic signed [15:0] vx, logic signed [15:0] vy,
                            logic signed [15:0] wz, logic last);
        longint ax;
        longint ay;
        longint aw;
        longint speed;
        longint pen;
        longint rad;
        longint unsigned sum;
        longint unsigned x;
        longint unsigned y;
        ax = vx < 0 ? -longint'(vx) : longint'(vx);
        ay = vy < 0 ? -longint'(vy) : longint'(vy);
        aw = wz < 0 ? -longint'(wz) : longint'(wz);
        if (enable) begin
            speed = longint'(root_floor(ax * ax + ay * ay));
            if (vx <= 0) speed = -speed;
            pen = 0;
            if (speed - max_speed > 0) pen += speed - max_speed;
            if (min_speed - speed > 0) pen += min_speed - speed;
            if (ackermann_mode && wz != 0) begin
                rad = (longint'(min_turn_radius) << 4) - (ax << 12) / aw;
                if (rad > 0) pen += rad;
            end
            sum = longint'(penalty_sum) + ((pen * longint'(step_time)) >>> 12);
            penalty_sum = sum > 64'hFF_FFFF_FFFF ? 40'hFF_FFFF_FFFF : sum[39:0];
        end
        if (last) begin
            if (!enable) begin
                pending_costs.push_back(32'd0);
            end else begin
                x = (longint'(penalty_sum) * weight_q8) >> 8;
                if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
                y = 65536;
                for (int i = 0; i < pow_exp; i++) begin
                    y = (y * x) >> 16;
                    if (y > 64'hFFFF_FFFF) y = 64'hFFFF_FFFF;
                end
                pending_costs.push_back(y[31:0]);
            end
            penalty_sum = 0;
        end
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_cost(logic [31:0] got);
        logic [31:0] want;
        if (pending_costs.size() == 0) begin
            report($sformatf("unexpected cost %h", got));
            return;
        end
        want = pending_costs.pop_front();
        if (got !== want) begin
            report($sformatf("trajectory_cost got %h want %h", got, want));
        end
    endtask
endclass

module tb_top;
    import tvc_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] yaw_rate;
    logic        last_step;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] trajectory_cost;

    cost_board board;
    int  idle_cycles;
    int  steps_sent;
    bit  hold_off;

    trajectory_velocity_constraint_cost dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // scoreboard sampling at the edge, before testbench updates land
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                board.note_step(vel_x, vel_y, yaw_rate, last_step);
            if (out_valid && !out_stall)
                board.check_cost(trajectory_cost);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stall pattern, plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            case ((steps_sent / 300) % 3)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
    end

    initial
    begin
        repeat (600) @(posedge clk);
        wait (steps_sent > 900);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (idle_cycles > IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        board.set_reg(idx, val);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (board.pending_costs.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // offer one step and hold it until accepted; valid stays high across items
    task automatic send_step(logic [15:0] vx, logic [15:0] vy, logic [15:0] wz, logic last);
        in_valid  <= 1'b1;
        vel_x     <= vx;
        vel_y     <= vy;
        yaw_rate  <= wz;
        last_step <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        steps_sent++;
    endtask

    task automatic pause_sender();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] rand_vel();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 16383) - 8192);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_trajectories(int count);
        int len;
        int n;
        n = 0;
        while (n < count) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                send_step(rand_vel(), rand_vel(),
                          ($urandom_range(0, 4) == 0) ? 16'h0000 : rand_vel(),
                          i == len - 1);
                n++;
                pause_sender();
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_config(bit extreme);
        write_reg(CFG_ENABLE, 16'($urandom_range(0, 5) != 0));
        write_reg(CFG_POW_EXP, extreme ? 16'd7 : 16'($urandom_range(0, 4)));
        write_reg(CFG_WEIGHT, extreme ? 16'hFFFF : 16'($urandom_range(0, 2048)));
        write_reg(CFG_MAX_SPEED, extreme ? 16'h8000 : 16'($urandom));
        write_reg(CFG_MIN_SPEED, extreme ? 16'h7FFF : 16'($urandom));
        write_reg(CFG_STEP_TIME, extreme ? 16'hFFFF : 16'($urandom));
        write_reg(CFG_ACKERMANN, 16'($urandom_range(0, 1)));
        write_reg(CFG_MIN_RADIUS, extreme ? 16'hFFFF : 16'($urandom));
    endtask

    initial
    begin
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_ENABLE;
        cfg_data = '0;
        in_valid = 1'b0;
        vel_x = '0;
        vel_y = '0;
        yaw_rate = '0;
        last_step = 1'b0;
        out_stall = 1'b0;
        idle_cycles = 0;
        steps_sent = 0;
        hold_off = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes at reset settings
        send_step(16'h7FFF, 16'h7FFF, 16'h0000, 1'b1);
        send_step(16'h8000, 16'h8000, 16'h8000, 1'b1);
        send_step(16'h0000, 16'h0000, 16'h7FFF, 1'b0);
        send_step(16'h1000, 16'hF000, 16'h0001, 1'b1);
        in_valid <= 1'b0;
        drain();
        // ackermann with zero and tiny yaw rate, min above max
        write_reg(CFG_ACKERMANN, 16'd1);
        write_reg(CFG_MIN_RADIUS, 16'hFFFF);
        write_reg(CFG_MAX_SPEED, 16'h8000);
        write_reg(CFG_MIN_SPEED, 16'h7FFF);
        write_reg(CFG_STEP_TIME, 16'hFFFF);
        write_reg(CFG_WEIGHT, 16'hFFFF);
        send_step(16'h0001, 16'h0000, 16'h0000, 1'b0);
        send_step(16'h0001, 16'h0000, 16'hFFFF, 1'b0);
        send_step(16'h8000, 16'h7FFF, 16'h0001, 1'b1);
        in_valid <= 1'b0;
        drain();
        // power zero, power above four, saturating power result over many steps
        write_reg(CFG_POW_EXP, 16'd0);
        send_step(16'h0100, 16'h0100, 16'h0100, 1'b1);
        in_valid <= 1'b0;
        drain();
        write_reg(CFG_POW_EXP, 16'd7);
        for (int i = 0; i < 12; i++) send_step(16'h8000, 16'h8000, 16'h0001, i == 11);
        in_valid <= 1'b0;
        drain();
        // disabled
        write_reg(CFG_ENABLE, 16'd0);
        send_step(16'h7FFF, 16'h0000, 16'h0001, 1'b0);
        send_step(16'h7FFF, 16'h0000, 16'h0001, 1'b1);
        in_valid <= 1'b0;
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            random_config(phase == 3);
            random_trajectories(320);
            drain();
        end

        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
